/* design/hpsm_pkg.sv */
// package for the head pose stability monitor: widths, codes, register indexes
`default_nettype none
package hpsm_pkg;

  localparam int WINDOW = 100;
  localparam int ANG_W  = 16;
  localparam int CHG_W  = ANG_W + 1;
  localparam int THR_W  = 15;
  localparam int CNT_W  = 8;
  localparam int WP_W   = $clog2(WINDOW);
  localparam int NW     = $clog2(WINDOW + 1);
  localparam int DW     = 2 * NW;
  localparam int SUM_W  = ANG_W + $clog2(WINDOW);
  localparam int SQ_W   = 2 * ANG_W - 1 + $clog2(WINDOW);
  localparam int MW     = 25;
  localparam int AW     = 2 * MW;
  localparam int QW     = 32;
  localparam int RW     = 16;
  localparam int LO_W   = 24;

  localparam logic [2:0] REG_TURN_THR      = 3'd0;
  localparam logic [2:0] REG_TILT_THR      = 3'd1;
  localparam logic [2:0] REG_TREMOR_THR    = 3'd2;
  localparam logic [2:0] REG_TREMOR_FRAMES = 3'd3;
  localparam logic [2:0] REG_POST_ROLL_THR = 3'd4;
  localparam logic [2:0] REG_POST_PITCH_THR = 3'd5;

  localparam logic [2:0] LOOK_CENTER = 3'd0;
  localparam logic [2:0] LOOK_UP     = 3'd1;
  localparam logic [2:0] LOOK_DOWN   = 3'd2;
  localparam logic [2:0] LOOK_LEFT   = 3'd3;
  localparam logic [2:0] LOOK_RIGHT  = 3'd4;

endpackage
`default_nettype wire

/* design/head_pose_stability_monitor.sv */
// head pose stability monitor top level
//
// One pose sample per request. While busy with a sample the block uses in turn
// a shared 25x25 multiplier (squares, sum squares, count products), a radix-2
// divider for the variance quotient, a bit-pair square root (one load and 16
// steps) and a hand-over of the result to the output register. The output
// register holds one result while the next sample is taken; a sample finishing
// before that result is taken waits for it.
// The user must write configuration registers through the cfg channel only while
// the block is idle; the block itself does not enforce this.
// cfg_ready is always high.
`default_nettype none
module head_pose_stability_monitor import hpsm_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [ANG_W-1:0] pitch_angle,
  input  wire logic signed [ANG_W-1:0] roll_angle,
  input  wire logic signed [ANG_W-1:0] yaw_angle,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [CHG_W-1:0]      pitch_change,
  output logic signed [CHG_W-1:0]      roll_change,
  output logic signed [CHG_W-1:0]      yaw_change,
  output logic                         turning_flag,
  output logic                         tilt_flag,
  output logic                         tremor_flag,
  output logic [THR_W-1:0]             stability,
  output logic [2:0]                   posture,
  output logic                         unsafe,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [2:0]              cfg_index,
  input  wire logic [15:0]             cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_SQRT, S_DONE} state_t;

  state_t state;
  logic [3:0] k;
  logic [4:0] dcnt;

  logic [THR_W-1:0] turn_thr, tilt_thr, tremor_thr, post_roll_thr, post_pitch_thr;
  logic [CNT_W-1:0] tremor_frames;

  logic signed [ANG_W-1:0] pmem [WINDOW];
  logic signed [ANG_W-1:0] rmem [WINDOW];
  logic signed [ANG_W-1:0] rd_p, rd_r;
  logic [WP_W-1:0] wp;
  logic full, was_full;
  logic [NW-1:0] n;

  logic signed [ANG_W-1:0] prev_p, prev_r, prev_y;
  logic signed [ANG_W-1:0] cur_p, cur_r, old_p, old_r;
  logic signed [SUM_W-1:0] psum, rsum;
  logic [SQ_W-1:0] psq, rsq;
  logic signed [AW-1:0] acc;
  logic signed [MW-1:0] ma, mb;
  logic signed [AW-1:0] prod;

  logic [DW-1:0] dvs, rem;
  logic [QW-1:0] dq;
  logic [QW-1:0] sv, sres, sbit;

  logic [CNT_W-1:0] tremor_count;
  logic tremor_latched;

  logic signed [CHG_W-1:0] h_pc, h_rc, h_yc;
  logic h_turn, h_tilt;
  logic [2:0] h_post;

  // input side decode
  logic signed [CHG_W-1:0] pe, re;
  logic [CHG_W-1:0] ap, ar;
  logic wp_last;
  logic [WP_W-1:0] wp_next;
  logic full_next;
  logic [2:0] post_next;

  always_comb begin
    pe = {pitch_angle[ANG_W-1], pitch_angle};
    re = {roll_angle[ANG_W-1], roll_angle};
    ap = pe[CHG_W-1] ? CHG_W'(-pe) : CHG_W'(pe);
    ar = re[CHG_W-1] ? CHG_W'(-re) : CHG_W'(re);
    wp_last = (wp == WP_W'(WINDOW - 1));
    wp_next = wp_last ? '0 : wp + 1'b1;
    full_next = full | wp_last;
    if (ar > {2'b00, post_roll_thr} && ar > ap) begin
      post_next = (!roll_angle[ANG_W-1] && roll_angle != '0) ? LOOK_UP : LOOK_DOWN;
    end else if (ap > {2'b00, post_pitch_thr} && ap > ar) begin
      post_next = (!pitch_angle[ANG_W-1] && pitch_angle != '0) ? LOOK_RIGHT : LOOK_LEFT;
    end else begin
      post_next = LOOK_CENTER;
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (k)
      4'd0: begin ma = MW'(cur_p); mb = MW'(cur_p); end
      4'd1: begin ma = MW'(old_p); mb = MW'(old_p); end
      4'd2: begin ma = MW'(cur_r); mb = MW'(cur_r); end
      4'd3: begin ma = MW'(old_r); mb = MW'(old_r); end
      4'd4: begin ma = MW'(psum); mb = MW'(psum); end
      4'd5: begin ma = MW'(rsum); mb = MW'(rsum); end
      4'd6: begin
        ma = {{(MW-NW){1'b0}}, n};
        mb = {{(MW-LO_W){1'b0}}, psq[LO_W-1:0]};
      end
      4'd7: begin
        ma = {{(MW-NW){1'b0}}, n};
        mb = {{(MW-SQ_W+LO_W){1'b0}}, psq[SQ_W-1:LO_W]};
      end
      4'd8: begin
        ma = {{(MW-NW){1'b0}}, n};
        mb = {{(MW-LO_W){1'b0}}, rsq[LO_W-1:0]};
      end
      4'd9: begin
        ma = {{(MW-NW){1'b0}}, n};
        mb = {{(MW-SQ_W+LO_W){1'b0}}, rsq[SQ_W-1:LO_W]};
      end
      4'd10: begin ma = {{(MW-NW){1'b0}}, n}; mb = {{(MW-NW){1'b0}}, n}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // divider and root steps
  logic [DW:0] r2;
  logic r2_ge;
  logic [QW-1:0] strial;
  logic s_ge;
  logic [RW:0] sq_full;
  logic sq_over;
  logic [CNT_W-1:0] cnt_inc;

  always_comb begin
    r2 = {rem, dq[QW-1]};
    r2_ge = (r2 >= {1'b0, dvs});
    strial = sres + sbit;
    s_ge = (sv >= strial);
    sq_full = {1'b0, sres[RW-1:0]};
    sq_over = (sq_full > {{(RW+1-THR_W){1'b0}}, tremor_thr});
    cnt_inc = (tremor_count == '1) ? tremor_count : tremor_count + 1'b1;
  end

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    rd_p <= pmem[wp];
    rd_r <= rmem[wp];
    if (in_valid && in_ready) begin
      pmem[wp] <= pitch_angle;
      rmem[wp] <= roll_angle;
    end
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (rst) begin
      state <= S_IDLE;
      k <= '0;
      dcnt <= '0;
      wp <= '0;
      full <= 1'b0;
      psum <= '0;
      rsum <= '0;
      psq <= '0;
      rsq <= '0;
      prev_p <= '0;
      prev_r <= '0;
      prev_y <= '0;
      tremor_count <= '0;
      tremor_latched <= 1'b0;
      out_valid <= 1'b0;
      turn_thr <= THR_W'(2000);
      tilt_thr <= THR_W'(3000);
      tremor_thr <= THR_W'(300);
      tremor_frames <= CNT_W'(10);
      post_roll_thr <= THR_W'(2000);
      post_pitch_thr <= THR_W'(1500);
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TURN_THR:       turn_thr <= cfg_data[THR_W-1:0];
          REG_TILT_THR:       tilt_thr <= cfg_data[THR_W-1:0];
          REG_TREMOR_THR:     tremor_thr <= cfg_data[THR_W-1:0];
          REG_TREMOR_FRAMES:  tremor_frames <= cfg_data[CNT_W-1:0];
          REG_POST_ROLL_THR:  post_roll_thr <= cfg_data[THR_W-1:0];
          REG_POST_PITCH_THR: post_pitch_thr <= cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            h_pc <= pe - CHG_W'(prev_p);
            h_rc <= re - CHG_W'(prev_r);
            h_yc <= CHG_W'(yaw_angle) - CHG_W'(prev_y);
            h_turn <= (ap > {2'b00, turn_thr});
            h_tilt <= (ar > {2'b00, tilt_thr});
            h_post <= post_next;
            prev_p <= pitch_angle;
            prev_r <= roll_angle;
            prev_y <= yaw_angle;
            cur_p <= pitch_angle;
            cur_r <= roll_angle;
            old_p <= rd_p;
            old_r <= rd_r;
            was_full <= full;
            psum <= psum + SUM_W'(pitch_angle) - (full ? SUM_W'(rd_p) : '0);
            rsum <= rsum + SUM_W'(roll_angle) - (full ? SUM_W'(rd_r) : '0);
            wp <= wp_next;
            full <= full_next;
            n <= full_next ? NW'(WINDOW) : NW'(wp_next);
            acc <= '0;
            k <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          k <= k + 1'b1;
          case (k)
            4'd1: psq <= psq + SQ_W'(prod);
            4'd2: if (was_full) psq <= psq - SQ_W'(prod);
            4'd3: rsq <= rsq + SQ_W'(prod);
            4'd4: if (was_full) rsq <= rsq - SQ_W'(prod);
            4'd5, 4'd6: acc <= acc - prod;
            4'd7, 4'd9: acc <= acc + prod;
            4'd8, 4'd10: acc <= acc + (prod <<< LO_W);
            4'd11: begin
              dvs <= prod[DW-1:0];
              rem <= acc[DW+QW-1:QW];
              dq <= acc[QW-1:0];
              dcnt <= '0;
              state <= S_DIV;
            end
            default: ;
          endcase
        end
        S_DIV: begin
          rem <= r2_ge ? DW'(r2 - {1'b0, dvs}) : r2[DW-1:0];
          dq <= {dq[QW-2:0], r2_ge};
          dcnt <= dcnt + 1'b1;
          if (dcnt == '1) begin
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (dcnt == '0) begin
            sv <= dq;
            sres <= '0;
            sbit <= QW'(1) << (QW - 2);
            dcnt <= 5'd1;
          end else begin
            if (s_ge) begin
              sv <= sv - strial;
              sres <= (sres >> 1) + sbit;
            end else begin
              sres <= sres >> 1;
            end
            sbit <= sbit >> 2;
            if (sbit == QW'(1)) begin
              dcnt <= '0;
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            if (sq_over) begin
              tremor_count <= cnt_inc;
              tremor_latched <= tremor_latched | (cnt_inc > tremor_frames);
              tremor_flag <= tremor_latched | (cnt_inc > tremor_frames);
              unsafe <= h_tilt | tremor_latched | (cnt_inc > tremor_frames);
            end else begin
              tremor_count <= '0;
              tremor_latched <= 1'b0;
              tremor_flag <= 1'b0;
              unsafe <= h_tilt;
            end
            stability <= sq_full[RW-1] ? '1 : sq_full[THR_W-1:0];
            pitch_change <= h_pc;
            roll_change <= h_rc;
            yaw_change <= h_yc;
            turning_flag <= h_turn;
            tilt_flag <= h_tilt;
            posture <= h_post;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("block ready right after taking a request");
  a_unsafe_or: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (unsafe == (tilt_flag || tremor_flag)))
    else $error("unsafe flag does not match tilt and tremor");
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < dvs)
    else $error("divider remainder out of range");
  a_tremor_count: assert property (@(posedge clk) disable iff (rst)
    tremor_latched |-> tremor_count != '0)
    else $error("tremor latched with zero count");
`endif

endmodule
`default_nettype wire
